[src/kts_pkg.sv]
package kts_pkg;

  // table sizes
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned MaxClients = 8;

  // fixed field widths
  localparam int unsigned KeyW   = 48;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CslotW = 3;

  // operation codes
  typedef enum logic [2:0] {
    MODE_LOOKUP = 3'd0,
    MODE_UPSERT = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_SEEN   = 3'd3,
    MODE_ADDCL  = 3'd4,
    MODE_RMCL   = 3'd5,
    MODE_SETSC  = 3'd6,
    MODE_NOP    = 3'd7
  } mode_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRD,
    ST_SCK,
    ST_DEC,
    ST_MVWR,
    ST_CPRD,
    ST_CPWR,
    ST_ERD,
    ST_ECK,
    ST_CRD,
    ST_CCK,
    ST_LWR,
    ST_DONE
  } state_e;

endpackage

[src/kts_req_if.sv]
interface kts_req_if import kts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [KeyW-1:0]   ap_key;
  logic [KeyW-1:0]   client_key;
  logic [ChanW-1:0]  channel;
  logic [TimeW-1:0]  now_time;
  logic [ScoreW-1:0] score_value;

  modport source (output valid, mode, ap_key, client_key, channel, now_time, score_value,
                  input ready);
  modport sink   (input valid, mode, ap_key, client_key, channel, now_time, score_value,
                  output ready);
endinterface

[src/kts_rsp_if.sv]
interface kts_rsp_if import kts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [SlotW-1:0]  slot;
  logic              evicted;
  logic [CslotW-1:0] client_slot;

  modport source (output valid, found, slot, evicted, client_slot, input ready);
  modport sink   (input valid, found, slot, evicted, client_slot, output ready);
endinterface

[src/keyed_table_score_evict.sv]
// operation: a key search over the entries, then a decision; lookup, upsert, seen and set
//   score end there; remove moves the last entry into the hole and copies its client list;
//   each client list walked reads and compares its clients in turn, and a dropped client is
//   replaced by the last one in that list; add client walks every entry's list
// flow: one request at a time; a stalled result holds the block in its last state
// reset: entry count and control clear at once; the memories are not cleared
module keyed_table_score_evict import kts_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MaxEntries,
  parameter int unsigned MAX_CLIENTS = MaxClients
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kts_req_if.sink   req_i,
  kts_rsp_if.source rsp_o
);

  localparam int unsigned EW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW   = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int unsigned CCW  = $clog2(MAX_CLIENTS + 1);
  localparam int unsigned CD   = MAX_ENTRIES * MAX_CLIENTS;
  localparam int unsigned CAW  = $clog2(CD);

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ScoreW-1:0] score;
    logic [ChanW-1:0]  chan;
    logic [TimeW-1:0]  tstamp;
    logic [CCW-1:0]    ccnt;
  } ent_t;

  typedef struct packed {
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] tstamp;
  } cli_t;

  function automatic logic [CAW-1:0] caddr(input logic [EW-1:0] x, input logic [CW-1:0] j);
    caddr = CAW'(CAW'(x) * CAW'(MAX_CLIENTS) + CAW'(j));
  endfunction

  // memories
  ent_t emem [MAX_ENTRIES];
  cli_t cmem [CD];
  logic           e_we, c_we;
  logic [EW-1:0]  e_waddr, e_raddr;
  logic [CAW-1:0] c_waddr, c_raddr;
  ent_t           e_wdata, e_rdata_q;
  cli_t           c_wdata, c_rdata_q;

  always_ff @(posedge clk_i) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    e_rdata_q <= emem[e_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    c_rdata_q <= cmem[c_raddr];
  end

  // control and working registers
  state_e            state_q, state_d;
  logic [CNTW-1:0]   cnt_q, cnt_d, idx_q, idx_d, x_q, x_d;
  logic              hit_q, hit_d, tgt_q, tgt_d;
  logic [EW-1:0]     e_q, e_d, min_q, min_d;
  logic [ScoreW-1:0] min_sc_q, min_sc_d;
  logic [TimeW-1:0]  min_t_q, min_t_d, old_t_q, old_t_d;
  logic [CW-1:0]     old_q, old_d;
  logic [CCW-1:0]    j_q, j_d;
  ent_t              ent_q, ent_d;
  mode_e             mode_q, mode_d;
  logic [KeyW-1:0]   ap_q, ap_d, ck_q, ck_d;
  logic [ChanW-1:0]  ch_q, ch_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic [ScoreW-1:0] sc_q, sc_d;
  logic              rf_q, rf_d, rev_q, rev_d;
  logic [EW-1:0]     rs_q, rs_d;
  logic [CW-1:0]     rcs_q, rcs_d;
  logic              ov_q, ov_d, of_q, of_d, oe_q, oe_d;
  logic [SlotW-1:0]  os_q, os_d;
  logic [CslotW-1:0] ocs_q, ocs_d;

  logic [EW-1:0] ne;
  logic [CW-1:0] jw;
  logic [CW-1:0] cs;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;  x_q <= x_d;  hit_q <= hit_d;  tgt_q <= tgt_d;
    e_q <= e_d;  min_q <= min_d;  min_sc_q <= min_sc_d;  min_t_q <= min_t_d;
    old_q <= old_d;  old_t_q <= old_t_d;  j_q <= j_d;  ent_q <= ent_d;
    mode_q <= mode_d;  ap_q <= ap_d;  ck_q <= ck_d;  ch_q <= ch_d;
    now_q <= now_d;  sc_q <= sc_d;
    rf_q <= rf_d;  rev_q <= rev_d;  rs_q <= rs_d;  rcs_q <= rcs_d;
    of_q <= of_d;  oe_q <= oe_d;  os_q <= os_d;  ocs_q <= ocs_d;
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = ov_q;
  assign rsp_o.found       = of_q;
  assign rsp_o.slot        = os_q;
  assign rsp_o.evicted     = oe_q;
  assign rsp_o.client_slot = ocs_q;

  assign jw = j_q[CW-1:0];

  // sequencer: scan, decide, read-modify-write
  always_comb begin
    state_d = state_q;  cnt_d = cnt_q;  idx_d = idx_q;  x_d = x_q;
    hit_d = hit_q;  tgt_d = tgt_q;  e_d = e_q;  min_d = min_q;
    min_sc_d = min_sc_q;  min_t_d = min_t_q;  old_d = old_q;  old_t_d = old_t_q;
    j_d = j_q;  ent_d = ent_q;  mode_d = mode_q;  ap_d = ap_q;  ck_d = ck_q;
    ch_d = ch_q;  now_d = now_q;  sc_d = sc_q;
    rf_d = rf_q;  rev_d = rev_q;  rs_d = rs_q;  rcs_d = rcs_q;
    ov_d = ov_q;  of_d = of_q;  oe_d = oe_q;  os_d = os_q;  ocs_d = ocs_q;
    e_we = 1'b0;  e_waddr = '0;  e_wdata = ent_q;  e_raddr = '0;
    c_we = 1'b0;  c_waddr = '0;  c_wdata = '{key: ck_q, tstamp: now_q};  c_raddr = '0;
    ne = '0;
    cs = '0;

    // output register drains independently
    if (ov_q && rsp_o.ready) ov_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          mode_d = mode_e'(req_i.mode);
          ap_d   = req_i.ap_key;
          ck_d   = req_i.client_key;
          ch_d   = req_i.channel;
          now_d  = req_i.now_time;
          sc_d   = req_i.score_value;
          idx_d  = '0;
          hit_d  = 1'b0;
          rf_d   = 1'b0;
          rev_d  = 1'b0;
          rs_d   = '0;
          rcs_d  = '0;
          state_d = ST_SRD;
        end
      end

      // key search, also tracking the eviction victim
      ST_SRD: begin
        if (idx_q >= cnt_q) begin
          state_d = ST_DEC;
        end else begin
          e_raddr = idx_q[EW-1:0];
          state_d = ST_SCK;
        end
      end

      ST_SCK: begin
        if (e_rdata_q.key == ap_q) begin
          hit_d   = 1'b1;
          e_d     = idx_q[EW-1:0];
          ent_d   = e_rdata_q;
          state_d = ST_DEC;
        end else begin
          if (idx_q == '0 || e_rdata_q.score < min_sc_q ||
              (e_rdata_q.score == min_sc_q && e_rdata_q.tstamp < min_t_q)) begin
            min_d    = idx_q[EW-1:0];
            min_sc_d = e_rdata_q.score;
            min_t_d  = e_rdata_q.tstamp;
          end
          idx_d   = idx_q + 1'b1;
          state_d = ST_SRD;
        end
      end

      ST_DEC: begin
        state_d = ST_DONE;
        if (mode_q == MODE_UPSERT) begin
          if (hit_q) begin
            rf_d = 1'b1;
            rs_d = e_q;
          end else begin
            if (cnt_q < CNTW'(MAX_ENTRIES)) begin
              ne    = cnt_q[EW-1:0];
              cnt_d = cnt_q + 1'b1;
            end else begin
              ne    = min_q;
              rev_d = 1'b1;
            end
            e_we    = 1'b1;
            e_waddr = ne;
            e_wdata = '{key: ap_q, score: '0, chan: '0, tstamp: '0, ccnt: '0};
            rs_d    = ne;
          end
        end else if (hit_q && mode_q != MODE_NOP) begin
          rf_d = 1'b1;
          rs_d = e_q;
          unique case (mode_q)
            MODE_REMOVE: begin
              e_raddr = EW'(cnt_q - 1'b1);
              x_d     = cnt_q - 1'b1;
              cnt_d   = cnt_q - 1'b1;
              state_d = ST_MVWR;
            end
            MODE_SEEN: begin
              e_we    = 1'b1;
              e_waddr = e_q;
              e_wdata = ent_q;
              if (ch_q != '0) e_wdata.chan = ch_q;
              e_wdata.tstamp = now_q;
            end
            MODE_SETSC: begin
              e_we    = 1'b1;
              e_waddr = e_q;
              e_wdata = ent_q;
              e_wdata.score = sc_q;
            end
            MODE_ADDCL: begin
              tgt_d   = 1'b0;
              x_d     = '0;
              state_d = ST_ERD;
            end
            MODE_RMCL: begin
              tgt_d   = 1'b0;
              x_d     = CNTW'(e_q);
              state_d = ST_ERD;
            end
            default: ;
          endcase
        end
      end

      // remove: move the last entry and its clients into the hole
      ST_MVWR: begin
        e_we    = 1'b1;
        e_waddr = e_q;
        e_wdata = e_rdata_q;
        j_d     = '0;
        state_d = ST_CPRD;
      end

      ST_CPRD: begin
        c_raddr = caddr(x_q[EW-1:0], jw);
        state_d = ST_CPWR;
      end

      ST_CPWR: begin
        c_we    = 1'b1;
        c_waddr = caddr(e_q, jw);
        c_wdata = c_rdata_q;
        if (j_q == CCW'(MAX_CLIENTS - 1)) begin
          state_d = ST_DONE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_CPRD;
        end
      end

      // per-entry client list walk
      ST_ERD: begin
        if (mode_q == MODE_ADDCL && !tgt_q) begin
          if (x_q >= cnt_q) begin
            tgt_d = 1'b1;
            x_d   = CNTW'(e_q);
          end else if (x_q == CNTW'(e_q)) begin
            x_d = x_q + 1'b1;
          end else begin
            e_raddr = x_q[EW-1:0];
            state_d = ST_ECK;
          end
        end else begin
          e_raddr = x_q[EW-1:0];
          state_d = ST_ECK;
        end
      end

      ST_ECK: begin
        ent_d   = e_rdata_q;
        j_d     = '0;
        state_d = ST_CRD;
      end

      ST_CRD: begin
        if (j_q >= ent_q.ccnt) begin
          if (tgt_q) begin
            // no match in target: append or replace oldest
            if (ent_q.ccnt < CCW'(MAX_CLIENTS)) begin
              cs      = ent_q.ccnt[CW-1:0];
              e_we    = 1'b1;
              e_waddr = x_q[EW-1:0];
              e_wdata = ent_q;
              e_wdata.ccnt = ent_q.ccnt + 1'b1;
            end else begin
              cs    = old_q;
              rev_d = 1'b1;
            end
            c_we    = 1'b1;
            c_waddr = caddr(x_q[EW-1:0], cs);
            rcs_d   = cs;
            state_d = ST_DONE;
          end else if (mode_q == MODE_RMCL) begin
            rf_d    = 1'b0;
            state_d = ST_DONE;
          end else begin
            x_d     = x_q + 1'b1;
            state_d = ST_ERD;
          end
        end else begin
          c_raddr = caddr(x_q[EW-1:0], jw);
          state_d = ST_CCK;
        end
      end

      ST_CCK: begin
        if (j_q == '0 || c_rdata_q.tstamp < old_t_q) begin
          old_d   = jw;
          old_t_d = c_rdata_q.tstamp;
        end
        if (c_rdata_q.key == ck_q) begin
          if (tgt_q) begin
            c_we    = 1'b1;
            c_waddr = caddr(x_q[EW-1:0], jw);
            rcs_d   = jw;
            state_d = ST_DONE;
          end else begin
            c_raddr = caddr(x_q[EW-1:0], CW'(ent_q.ccnt - 1'b1));
            state_d = ST_LWR;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_CRD;
        end
      end

      // drop: last client fills the freed slot
      ST_LWR: begin
        c_we    = 1'b1;
        c_waddr = caddr(x_q[EW-1:0], jw);
        c_wdata = c_rdata_q;
        e_we    = 1'b1;
        e_waddr = x_q[EW-1:0];
        e_wdata = ent_q;
        e_wdata.ccnt = ent_q.ccnt - 1'b1;
        if (mode_q == MODE_RMCL) begin
          rcs_d   = jw;
          state_d = ST_DONE;
        end else begin
          x_d     = x_q + 1'b1;
          state_d = ST_ERD;
        end
      end

      // result transfer into the output register
      ST_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          of_d    = rf_q;
          oe_d    = rev_q;
          os_d    = SlotW'(rs_q);
          ocs_d   = CslotW'(rcs_q);
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[dv/tb_keyed_table_score_evict.sv]
module tb_keyed_table_score_evict;
  import kts_pkg::*;

  typedef struct packed {
    mode_e             mode;
    logic [KeyW-1:0]   ap_key;
    logic [KeyW-1:0]   client_key;
    logic [ChanW-1:0]  channel;
    logic [TimeW-1:0]  now_time;
    logic [ScoreW-1:0] score_value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [SlotW-1:0]  slot;
    logic              evicted;
    logic [CslotW-1:0] client_slot;
  } rsp_t;

  // table model and queue of pending answers
  class table_scoreboard;
    int unsigned       n_ent;
    logic [KeyW-1:0]   ent_key  [MaxEntries];
    logic [ScoreW-1:0] ent_score[MaxEntries];
    logic [ChanW-1:0]  ent_chan [MaxEntries];
    logic [TimeW-1:0]  ent_time [MaxEntries];
    int unsigned       n_cl     [MaxEntries];
    logic [KeyW-1:0]   cl_key   [MaxEntries][MaxClients];
    logic [TimeW-1:0]  cl_time  [MaxEntries][MaxClients];
    rsp_t              pending[$];
    int unsigned       n_evict, n_cl_replace, n_mode[8];

    function int drop_client(int e, logic [KeyW-1:0] k);
      int n;
      n = n_cl[e];
      for (int i = 0; i < n; i++) begin
        if (cl_key[e][i] == k) begin
          cl_key[e][i]  = cl_key[e][n-1];
          cl_time[e][i] = cl_time[e][n-1];
          n_cl[e] = n - 1;
          return i;
        end
      end
      return -1;
    endfunction

    // apply one accepted transfer and queue its answer
    function void note(req_t r);
      int   hit;
      int   e;
      int   n;
      int   rc;
      bit   done;
      rsp_t x;
      hit = -1;
      x = '0;
      n_mode[r.mode]++;
      for (int i = 0; i < n_ent; i++)
        if (hit < 0 && ent_key[i] == r.ap_key) hit = i;
      e = (hit < 0) ? 0 : hit;
      if (r.mode == MODE_UPSERT) begin
        if (hit >= 0) begin
          x.found = 1'b1;
          x.slot  = SlotW'(e);
        end else begin
          if (n_ent < MaxEntries) begin
            e = n_ent;
            n_ent++;
          end else begin
            e = 0;
            for (int i = 1; i < n_ent; i++)
              if (ent_score[i] < ent_score[e] ||
                  (ent_score[i] == ent_score[e] && ent_time[i] < ent_time[e])) e = i;
            x.evicted = 1'b1;
            n_evict++;
          end
          ent_key[e] = r.ap_key;
          ent_score[e] = '0;
          ent_chan[e] = '0;
          ent_time[e] = '0;
          n_cl[e] = 0;
          x.slot = SlotW'(e);
        end
      end else if (hit >= 0 && r.mode != MODE_NOP) begin
        x.slot  = SlotW'(e);
        x.found = 1'b1;
        case (r.mode)
          MODE_REMOVE: begin
            ent_key[e]   = ent_key[n_ent-1];
            ent_score[e] = ent_score[n_ent-1];
            ent_chan[e]  = ent_chan[n_ent-1];
            ent_time[e]  = ent_time[n_ent-1];
            n_cl[e]      = n_cl[n_ent-1];
            for (int j = 0; j < MaxClients; j++) begin
              cl_key[e][j]  = cl_key[n_ent-1][j];
              cl_time[e][j] = cl_time[n_ent-1][j];
            end
            n_ent--;
          end
          MODE_SEEN: begin
            if (r.channel != 0) ent_chan[e] = r.channel;
            ent_time[e] = r.now_time;
          end
          MODE_ADDCL: begin
            done = 1'b0;
            for (int i = 0; i < n_ent; i++)
              if (i != e) rc = drop_client(i, r.client_key);
            n = n_cl[e];
            for (int i = 0; i < n; i++) begin
              if (!done && cl_key[e][i] == r.client_key) begin
                cl_time[e][i] = r.now_time;
                x.client_slot = CslotW'(i);
                done = 1'b1;
              end
            end
            if (!done) begin
              if (n < MaxClients) begin
                x.client_slot = CslotW'(n);
                n_cl[e] = n + 1;
              end else begin
                rc = 0;
                for (int i = 1; i < MaxClients; i++)
                  if (cl_time[e][i] < cl_time[e][rc]) rc = i;
                x.client_slot = CslotW'(rc);
                x.evicted = 1'b1;
                n_cl_replace++;
              end
              cl_key[e][x.client_slot]  = r.client_key;
              cl_time[e][x.client_slot] = r.now_time;
            end
          end
          MODE_RMCL: begin
            rc = drop_client(e, r.client_key);
            if (rc >= 0) x.client_slot = CslotW'(rc);
            else x.found = 1'b0;
          end
          MODE_SETSC: ent_score[e] = r.score_value;
          default: ;
        endcase
      end
      pending.push_back(x);
    endfunction

    // compare one result with the oldest answer; msg is empty when it matches
    function string check(rsp_t got);
      rsp_t x;
      if (pending.size() == 0) return "result with nothing pending";
      x = pending.pop_front();
      if (got.found !== x.found || got.slot !== x.slot ||
          got.evicted !== x.evicted || got.client_slot !== x.client_slot)
        return $sformatf("got found=%0d slot=%0d evicted=%0d cslot=%0d, want %0d %0d %0d %0d",
                         got.found, got.slot, got.evicted, got.client_slot,
                         x.found, x.slot, x.evicted, x.client_slot);
      return "";
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  kts_req_if req_if();
  kts_rsp_if rsp_if();
  table_scoreboard sb;
  int unsigned n_errors;
  int unsigned burst_left;
  logic [KeyW-1:0] ap_pool[20];
  logic [KeyW-1:0] cl_pool[24];

  keyed_table_score_evict dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("keyed_table_score_evict regression: fail");
    $finish;
  end

  task automatic report(string msg);
    n_errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // drive one transfer, with bursts and random gaps in between
  task automatic send(req_t r);
    if (burst_left == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(0, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    req_if.mode        = r.mode;
    req_if.ap_key      = r.ap_key;
    req_if.client_key  = r.client_key;
    req_if.channel     = r.channel;
    req_if.now_time    = r.now_time;
    req_if.score_value = r.score_value;
    req_if.valid       = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note(r);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic req_t mk(mode_e m, logic [KeyW-1:0] ap, logic [KeyW-1:0] ck,
                              logic [ChanW-1:0] ch, logic [TimeW-1:0] t,
                              logic [ScoreW-1:0] s);
    req_t r;
    r.mode = m; r.ap_key = ap; r.client_key = ck;
    r.channel = ch; r.now_time = t; r.score_value = s;
    return r;
  endfunction

  function automatic logic [KeyW-1:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // random transfer, mostly on pooled keys so entries and clients get hit
  function automatic req_t rand_req();
    req_t r;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 22) r.mode = MODE_UPSERT;
    else if (p < 30) r.mode = MODE_LOOKUP;
    else if (p < 36) r.mode = MODE_REMOVE;
    else if (p < 50) r.mode = MODE_SEEN;
    else if (p < 76) r.mode = MODE_ADDCL;
    else if (p < 86) r.mode = MODE_RMCL;
    else if (p < 98) r.mode = MODE_SETSC;
    else r.mode = MODE_NOP;
    r.ap_key = ($urandom_range(0, 19) == 0) ? rand_key() : ap_pool[$urandom_range(0, 19)];
    r.client_key = ($urandom_range(0, 19) == 0) ? rand_key() : cl_pool[$urandom_range(0, 23)];
    r.channel = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom());
    r.now_time = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom();
    r.score_value = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom());
    return r;
  endfunction

  // receiver: random stall runs whose stall rate is redrawn periodically
  initial begin
    int unsigned stall_left;
    int unsigned stall_pct;
    int unsigned cyc;
    stall_left = 0;
    stall_pct = 0;
    cyc = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (cyc % 300 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 70);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 8);
      end
    end
  end

  // result check on every accepted transfer
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      msg = sb.check('{rsp_if.found, rsp_if.slot, rsp_if.evicted, rsp_if.client_slot});
      if (msg != "") report(msg);
    end
  end

  initial begin
    logic [KeyW-1:0] ones;
    ones = '1;
    sb = new();
    n_errors = 0;
    burst_left = 0;
    req_if.valid = 1'b0;
    req_if.mode = MODE_NOP;
    req_if.ap_key = '0;
    req_if.client_key = '0;
    req_if.channel = '0;
    req_if.now_time = '0;
    req_if.score_value = '0;
    ap_pool[0] = '0;
    ap_pool[1] = ones;
    for (int i = 2; i < 20; i++) ap_pool[i] = rand_key();
    cl_pool[0] = '0;
    cl_pool[1] = ones;
    for (int i = 2; i < 24; i++) cl_pool[i] = rand_key();
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, every mode, absent entry and client cases
    send(mk(MODE_LOOKUP, '0, '0, '0, '0, '0));
    send(mk(MODE_SEEN, ones, '0, 8'hff, '1, '0));
    send(mk(MODE_UPSERT, '0, '0, '0, '0, '0));
    send(mk(MODE_UPSERT, ones, '0, '0, '0, '0));
    send(mk(MODE_UPSERT, ones, ones, '1, '1, '1));
    send(mk(MODE_LOOKUP, ones, '0, '0, '0, '0));
    send(mk(MODE_SEEN, ones, '0, 8'hff, '1, '0));
    send(mk(MODE_SEEN, ones, '0, 8'h00, 32'd5, '0));
    send(mk(MODE_SETSC, ones, '0, '0, '0, '1));
    send(mk(MODE_SETSC, '0, '0, '0, '0, '0));
    send(mk(MODE_ADDCL, '0, ones, '0, '1, '0));
    send(mk(MODE_ADDCL, '0, '0, '0, 32'd3, '0));
    send(mk(MODE_ADDCL, ones, ones, '0, 32'd9, '0));
    send(mk(MODE_ADDCL, ones, ones, '0, 32'd10, '0));
    send(mk(MODE_RMCL, '0, cl_pool[5], '0, '0, '0));
    send(mk(MODE_RMCL, ones, ones, '0, '0, '0));
    send(mk(MODE_RMCL, ap_pool[7], ones, '0, '0, '0));
    send(mk(MODE_NOP, ones, ones, '1, '1, '1));
    send(mk(MODE_REMOVE, '0, '0, '0, '0, '0));
    send(mk(MODE_REMOVE, '0, '0, '0, '0, '0));
    send(mk(MODE_LOOKUP, ones, '0, '0, '0, '0));
    drain();

    // random traffic with one full pause halfway
    for (int n = 0; n < 1380; n++) begin
      send(rand_req());
      if (n == 690) drain();
    end
    drain();
    repeat (400) @(negedge clk_i);

    $display("covered %0d upserts, %0d adds, %0d client removes, %0d entry removes",
             sb.n_mode[MODE_UPSERT], sb.n_mode[MODE_ADDCL], sb.n_mode[MODE_RMCL],
             sb.n_mode[MODE_REMOVE]);
    $display("entry evictions %0d, client replacements %0d", sb.n_evict, sb.n_cl_replace);
    if (n_errors == 0 && sb.pending.size() == 0) begin
      $display("keyed_table_score_evict regression: pass");
    end else begin
      $display("keyed_table_score_evict regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
src/kts_pkg.sv
src/kts_req_if.sv
src/kts_rsp_if.sv
src/keyed_table_score_evict.sv
dv/tb_keyed_table_score_evict.sv
